### hw/rtl/swm_pkg.sv
package swm_pkg;

   // Width of the window size register.
   localparam int CFG_WIDTH = 6;

   // Width of the request user sideband (start flag).
   localparam int REQ_USER_WIDTH = 1;

   // Bit position of the start flag inside req_tuser.
   localparam int USER_START_BIT = 0;

endpackage

### hw/rtl/sliding_window_median_core.sv
// Streaming sliding-window median. Each sample on the req stream joins a window
// of the last k samples (k taken from csr_data, 0 treated as 1, values above
// WINDOW_MAX treated as WINDOW_MAX); once the window has filled, every sample
// yields the lower median (rank ceil(k/2) from the smallest) on the rsp stream,
// while samples that only fill the window yield nothing. A sample with the start
// flag set in req_tuser drops the window and opens a new sequence; writing the
// window size does the same. The block takes one item per clock unless the rsp
// side stalls: an item is captured in the input register, the whole sorted
// window is then updated by parallel compares (remove the oldest entry, insert
// the new sample), and the median is captured in the output register. The
// sorted-window update is a combinational recurrence on the window registers
// and sets the clock-rate limit; a stalled rsp side holds one result and one
// pending item before req_tready drops. Nothing needs clearing after reset.
// Write the window size only while the block is idle.
module sliding_window_median_core #(
   parameter int WINDOW_MAX   = 32,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // tdata: [SAMPLE_WIDTH-1:0] sample, rest padding
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]           req_tdata,
   // tuser: [0] start_req
   input  logic [swm_pkg::REQ_USER_WIDTH-1:0]          req_tuser,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // tdata: [SAMPLE_WIDTH-1:0] median, rest zero
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]           rsp_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   input  logic [swm_pkg::CFG_WIDTH-1:0]               csr_data,
   input  logic                                       csr_valid,
   output logic                                       csr_ready
);

   localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int CW  = $clog2(WINDOW_MAX + 1);
   localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   // Control state
   logic [swm_pkg::CFG_WIDTH-1:0] size_ff;
   logic [CW-1:0]                 fill_ff, fill_in;
   logic                          in_valid_ff, in_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Payload
   logic                           in_start_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] median_ff, median_in;
   logic signed [SAMPLE_WIDTH-1:0] win_val_ff [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] win_val_in [WINDOW_MAX];
   logic        [AW-1:0]           win_age_ff [WINDOW_MAX];
   logic        [AW-1:0]           win_age_in [WINDOW_MAX];

   // Window update terms
   logic signed [SAMPLE_WIDTH-1:0] keep_val [WINDOW_MAX];
   logic        [AW-1:0]           keep_age [WINDOW_MAX];
   logic                           keep_le  [WINDOW_MAX];
   logic                           ent_le   [WINDOW_MAX];
   logic                           ent_rm   [WINDOW_MAX];

   logic          fire;
   logic          emit;
   logic [CW-1:0] k_eff;
   logic [CW-1:0] fill_base;
   logic [CW-1:0] keep_cnt;
   logic          full;
   logic [AW-1:0] rm_idx;
   logic [AW-1:0] mid_idx;

   // Advance the pending item when the output slot is free or being drained.
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDW'($unsigned(median_ff));

   always_comb begin
      int src;

      // Clamp the programmed size into 1..WINDOW_MAX.
      if (size_ff == '0) begin
         k_eff = CW'(1);
      end else if (32'(size_ff) > 32'(WINDOW_MAX)) begin
         k_eff = CW'(WINDOW_MAX);
      end else begin
         k_eff = CW'(size_ff);
      end

      // Drop the window on a start flag (or a stale count).
      fill_base = (in_start_ff || fill_ff > k_eff) ? '0 : fill_ff;
      full      = (fill_base == k_eff);
      keep_cnt  = full ? k_eff - CW'(1) : fill_base;
      mid_idx   = AW'((k_eff - CW'(1)) >> 1);

      // Locate the oldest entry (age k-1) when the window is full.
      rm_idx = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         ent_rm[i] = full && (32'(i) < 32'(fill_base)) &&
                     (32'(win_age_ff[i]) == 32'(k_eff) - 32'd1);
         ent_le[i] = (win_val_ff[i] <= in_sample_ff);
         if (ent_rm[i]) begin
            rm_idx = rm_idx | AW'(i);
         end
      end

      // Close the gap left by the removed entry.
      for (int j = 0; j < WINDOW_MAX; j++) begin
         src = (full && 32'(j) >= 32'(rm_idx) && j + 1 < WINDOW_MAX) ? j + 1 : j;
         keep_val[j] = win_val_ff[src];
         keep_age[j] = win_age_ff[src];
         keep_le[j]  = (32'(j) < 32'(keep_cnt)) && ent_le[src];
      end

      // Insert the new sample after every kept entry not greater than it.
      for (int j = 0; j < WINDOW_MAX; j++) begin
         if (keep_le[j]) begin
            win_val_in[j] = keep_val[j];
            win_age_in[j] = keep_age[j] + AW'(1);
         end else if (j == 0 || keep_le[(j > 0) ? j - 1 : 0]) begin
            win_val_in[j] = in_sample_ff;
            win_age_in[j] = '0;
         end else begin
            win_val_in[j] = keep_val[(j > 0) ? j - 1 : 0];
            win_age_in[j] = keep_age[(j > 0) ? j - 1 : 0] + AW'(1);
         end
      end

      fill_in   = full ? k_eff : fill_base + CW'(1);
      emit      = (fill_in == k_eff);
      median_in = win_val_in[mid_idx];

      // Hold the result until taken; load a new one when produced.
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= swm_pkg::CFG_WIDTH'(1);
         fill_ff      <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            size_ff <= csr_data;
            fill_ff <= '0;
         end else if (fire) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_start_ff  <= req_tuser[swm_pkg::USER_START_BIT];
         in_sample_ff <= $signed(req_tdata[SAMPLE_WIDTH-1:0]);
      end
      if (fire) begin
         for (int j = 0; j < WINDOW_MAX; j++) begin
            win_val_ff[j] <= win_val_in[j];
            win_age_ff[j] <= win_age_in[j];
         end
      end
      if (fire && emit) begin
         median_ff <= median_in;
      end
   end

endmodule

### hw/rtl/swm_checker.sv
module swm_checker #(
   parameter int SAMPLE_WIDTH = 32
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // A new result traces back to an item taken earlier on the req stream.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("rsp item without a matching req item");

   // Drop req_tready only behind a stalled result.
   a_req_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without output stall");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind sliding_window_median_core swm_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_swm_checker (.*);
